FILE: rtl/core/clss_pkg.sv
// ----------------------------------------------------------------------------
// clss_pkg: shared types and codes of the service selector
// Item kinds, result codes, mode codes, the table entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package clss_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int ID_W     = 32;
  localparam int HANDLE_W = 32;
  localparam int LIMIT_W  = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SELECT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SERVICE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  // Gate modes.
  localparam logic [MODE_W-1:0] MODE_ECHO    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOCK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BALANCE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_SINGLE;

  // Register word index of gate_mode.
  localparam logic REG_GATE_MODE = 1'b0;

  localparam logic [HANDLE_W-1:0] INVALID_HANDLE = 32'hFFFF_FFFF;
  localparam logic [LIMIT_W-1:0]  LOAD_MAX       = 16'hFFFF;

  // One table entry.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [LIMIT_W-1:0]  limit;
    logic [LIMIT_W-1:0]  load;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic dec_finish;
    logic scan_start;
    logic scan_step;
    logic update;
    logic shift_rd;
    logic shift_wr;
    logic shift_end;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dec_done;
    logic scan_done;
    logic shift_go;
    logic shift_more;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/clss_ctrl.sv
// ----------------------------------------------------------------------------
// clss_ctrl: sequencing state machine of the service selector
// Steps each request through decode and, where the table is needed, table
// scan, update and optional compaction, then hands off to the result register.
// ----------------------------------------------------------------------------
module clss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  clss_pkg::dp_stat_t stat,
  output clss_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.dec_done) begin
          cmd.dec_finish = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = stat.shift_go ? S_SHIFT_RD : S_DONE;
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          cmd.shift_end = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/clss_dpath.sv
// ----------------------------------------------------------------------------
// clss_dpath: table memory, scan logic and result register
// Holds the service table in a single-port-read memory, scans it one entry
// per cycle, applies attach, detach, add and remove, and keeps the result.
// ----------------------------------------------------------------------------
module clss_dpath #(
  parameter int MAX_SERVICES = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [clss_pkg::MODE_W-1:0]        gate_mode,
  input  clss_pkg::dp_cmd_t                  cmd,
  output clss_pkg::dp_stat_t                 stat,
  input  logic [clss_pkg::KIND_W-1:0]        in_kind,
  input  logic [clss_pkg::ID_W-1:0]          in_sid,
  input  logic [clss_pkg::HANDLE_W-1:0]      in_hnd,
  input  logic [clss_pkg::LIMIT_W-1:0]       in_lim,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [clss_pkg::STATUS_W-1:0]      out_status,
  output logic [clss_pkg::ID_W-1:0]          out_id
);

  localparam int CNT_W = $clog2(MAX_SERVICES + 1);
  localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;

  // Latched request.
  logic [clss_pkg::KIND_W-1:0]   kind;
  logic [clss_pkg::ID_W-1:0]     sid;
  logic [clss_pkg::HANDLE_W-1:0] hnd;
  logic [clss_pkg::LIMIT_W-1:0]  lim;

  // Table and scan state.
  clss_pkg::entry_t mem [MAX_SERVICES];
  clss_pkg::entry_t rd_q;
  clss_pkg::entry_t found_ent;
  clss_pkg::entry_t wr_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] raddr;
  logic [CNT_W-1:0] eidx;
  logic [CNT_W-1:0] found_idx;
  logic [CNT_W-1:0] sp;
  logic [CNT_W-1:0] sp_inc;
  logic [CNT_W-1:0] scan_lim;
  logic [CNT_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld;
  logic             found;
  logic             wr_en;

  // Result holding.
  logic [clss_pkg::STATUS_W-1:0] res_status;
  logic [clss_pkg::ID_W-1:0]     res_id;
  logic [clss_pkg::STATUS_W-1:0] dec_status;
  logic [clss_pkg::ID_W-1:0]     dec_id;
  logic [clss_pkg::STATUS_W-1:0] upd_status;
  logic [clss_pkg::ID_W-1:0]     upd_id;

  logic is_select;
  logic is_remove;
  logic is_add;
  logic balance;
  logic issue;
  logic room;
  logic hit;
  logic stop_hit;
  logic take;
  logic full;
  logic grow;
  logic dec_done;
  logic [clss_pkg::LIMIT_W-1:0] new_load;

  assign is_select = (kind == clss_pkg::KIND_SELECT);
  assign is_remove = (kind == clss_pkg::KIND_REMOVE);
  assign is_add    = (kind == clss_pkg::KIND_ADD);
  assign balance   = (gate_mode == clss_pkg::MODE_BALANCE);
  assign full      = (count == CNT_W'(MAX_SERVICES));
  assign sp_inc    = sp + CNT_W'(1);

  // Single-service mode only looks at the first entry.
  assign scan_lim = (is_select && gate_mode == clss_pkg::MODE_SINGLE) ? CNT_W'(1) : count;
  assign issue    = cmd.scan_step && (raddr < scan_lim);

  // Match test on the entry that the memory returned.
  assign room = (rd_q.limit == '0) || (rd_q.load < rd_q.limit);
  always_comb begin
    priority if (is_select) begin
      hit = room;
    end else if (is_remove) begin
      hit = (rd_q.handle == hnd);
    end else begin
      hit = (rd_q.id == sid);
    end
  end

  // Balance mode keeps the least loaded entry with room; other scans stop at
  // the first hit.
  assign stop_hit = rd_vld && hit && !(is_select && balance);
  assign take = rd_vld && ((is_select && balance)
                           ? (room && (!found || rd_q.load < found_ent.load))
                           : (hit && !found));

  assign stat.dec_done   = dec_done;
  assign stat.scan_done  = stop_hit || (raddr >= scan_lim);
  assign stat.shift_go   = is_remove && found;
  assign stat.shift_more = (sp_inc < count);
  assign stat.out_free   = !out_valid || out_ready;

  // Requests answered without touching the table.
  always_comb begin
    dec_done   = 1'b1;
    dec_status = clss_pkg::ST_OK;
    dec_id     = '0;
    priority if (is_select && gate_mode == clss_pkg::MODE_ECHO) begin
      dec_status = clss_pkg::ST_OK;
    end else if (is_select && count == '0) begin
      dec_status = clss_pkg::ST_NO_SERVICE;
    end else if (is_add && (sid == '0 || hnd == clss_pkg::INVALID_HANDLE)) begin
      dec_status = clss_pkg::ST_REFUSED;
    end else if (is_remove && hnd == clss_pkg::INVALID_HANDLE) begin
      dec_status = clss_pkg::ST_NOT_FOUND;
    end else if (kind > clss_pkg::KIND_REMOVE) begin
      dec_status = clss_pkg::ST_OK;
    end else begin
      dec_done = 1'b0;
    end
  end

  // Saturating count update for attach and detach.
  always_comb begin
    new_load = found_ent.load;
    if (kind == clss_pkg::KIND_ATTACH) begin
      if (found_ent.load != clss_pkg::LOAD_MAX) begin
        new_load = found_ent.load + 16'd1;
      end
    end else if (found_ent.load != '0) begin
      new_load = found_ent.load - 16'd1;
    end
  end

  // Outcome of a scanned request and the table write that it makes.
  always_comb begin
    upd_status = clss_pkg::ST_OK;
    upd_id     = '0;
    wr_en      = 1'b0;
    wr_ptr     = found_idx;
    wr_data    = found_ent;
    grow       = 1'b0;
    case (kind)
      clss_pkg::KIND_SELECT: begin
        upd_status = found ? clss_pkg::ST_OK : clss_pkg::ST_REFUSED;
        upd_id     = found ? found_ent.id : '0;
      end
      clss_pkg::KIND_ATTACH, clss_pkg::KIND_DETACH: begin
        upd_status    = found ? clss_pkg::ST_OK : clss_pkg::ST_NOT_FOUND;
        upd_id        = found ? sid : '0;
        wr_en         = cmd.update && found;
        wr_data.load  = new_load;
      end
      clss_pkg::KIND_ADD: begin
        if (found) begin
          upd_id = sid;
        end else if (full) begin
          upd_status = clss_pkg::ST_FULL;
        end else begin
          upd_id         = sid;
          grow           = cmd.update;
          wr_en          = cmd.update;
          wr_ptr         = count;
          wr_data.id     = sid;
          wr_data.handle = hnd;
          wr_data.limit  = lim;
          wr_data.load   = '0;
        end
      end
      clss_pkg::KIND_REMOVE: begin
        upd_status = found ? clss_pkg::ST_OK : clss_pkg::ST_NOT_FOUND;
        upd_id     = found ? found_ent.id : '0;
      end
      default: begin
        upd_status = clss_pkg::ST_OK;
      end
    endcase
    // Compaction copies the next entry one place up.
    if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_ptr  = sp;
      wr_data = rd_q;
    end
  end

  assign rd_addr = cmd.shift_rd ? sp_inc[IDX_W-1:0] : raddr[IDX_W-1:0];

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_ptr[IDX_W-1:0]] <= wr_data;
    end
  end

  // Request, scan and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind <= in_kind;
      sid  <= in_sid;
      hnd  <= in_hnd;
      lim  <= in_lim;
    end
    if (cmd.scan_start) begin
      raddr <= '0;
    end else if (issue) begin
      raddr <= raddr + CNT_W'(1);
    end
    if (issue) begin
      eidx <= raddr;
    end
    if (take) begin
      found_idx <= eidx;
      found_ent <= rd_q;
    end
    if (cmd.update) begin
      sp <= found_idx;
    end else if (cmd.shift_wr) begin
      sp <= sp_inc;
    end
    if (cmd.dec_finish) begin
      res_status <= dec_status;
      res_id     <= dec_id;
    end else if (cmd.update) begin
      res_status <= upd_status;
      res_id     <= upd_id;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_id     <= res_id;
    end
  end

  // Control state: fill count, scan flags and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (grow) begin
        count <= count + CNT_W'(1);
      end else if (cmd.shift_end) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.scan_start) begin
        rd_vld <= 1'b0;
        found  <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          rd_vld <= issue;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/capacity_limited_service_selector.sv
// ----------------------------------------------------------------------------
// capacity_limited_service_selector: service selector with a least-connections mode
// Keeps an ordered table of backend services and answers select, attach,
// detach, add and remove requests, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Requests answered without the table
// (echo select, select on an empty table, invalid add or remove, unknown
// kinds) go from decode straight to the result. All others scan the table
// through its single read port, one entry per cycle, looking at the whole
// table for a select in balance mode, only the first entry for a select in
// single mode, and entries up to the first hit otherwise. A remove then
// compacts the table, reading and writing back every entry behind the
// removed one, with a closing step. A finished result waits in the output
// register while the next request is accepted.
// gate_mode sits at byte address 0 of the register port.
module capacity_limited_service_selector #(
  parameter int MAX_SERVICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // service_id[31:0], socket_handle[63:32], conn_limit[79:64]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], chosen_id[34:3], zero fill[39:35]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [clss_pkg::MODE_W-1:0]   gate_mode;
  logic [clss_pkg::STATUS_W-1:0] out_status;
  logic [clss_pkg::ID_W-1:0]     out_id;
  clss_pkg::dp_cmd_t             cmd;
  clss_pkg::dp_stat_t            stat;
  logic                          reg_sel;

  // Register port: one mode register, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == clss_pkg::REG_GATE_MODE);
  assign prdata  = reg_sel ? {30'd0, gate_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_mode <= clss_pkg::MODE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      gate_mode <= pwdata[1:0];
    end
  end

  assign m_tdata = {5'd0, out_id, out_status};

  clss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clss_dpath #(
    .MAX_SERVICES (MAX_SERVICES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .gate_mode  (gate_mode),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_tuser),
    .in_sid     (s_tdata[31:0]),
    .in_hnd     (s_tdata[63:32]),
    .in_lim     (s_tdata[79:64]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_id     (out_id)
  );

endmodule

FILE: rtl/core/clss_checker.sv
// ----------------------------------------------------------------------------
// clss_checker: port-level checks for the service selector
// Watches the stream and register ports of the top level over time.
// ----------------------------------------------------------------------------
module clss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // One request at a time: the input side is busy after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a request is in work");

  // A written mode reads back on the next cycle.
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2]
    |=> paddr[2] || (prdata[1:0] == $past(pwdata[1:0])))
    else $error("mode register readback mismatch");

endmodule

bind capacity_limited_service_selector clss_checker u_clss_checker (.*);

FILE: tb/sv/capacity_limited_service_selector_tb.sv
// ----------------------------------------------------------------------------
// capacity_limited_service_selector_tb: self-checking bench of the selector
// Streams select, attach, detach, add and remove requests into the block under
// every gate mode and compares each result with a behavioral copy of the
// service table. The bench opens with a directed part, then drives a
// back-to-back attach run on one service, then random traffic with random
// idling and back-pressure on both streams.
// ----------------------------------------------------------------------------
module capacity_limited_service_selector_tb;

  localparam int MAX_SERVICES = 8;
  localparam int POOL_SIZE    = 10;
  localparam int PHASE_ITEMS  = 220;
  localparam int ATTACH_RUN   = 6;
  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_STALL   = 300;
  localparam int SETTLE_WAIT  = 40;

  typedef logic [clss_pkg::KIND_W-1:0] kind_t;

  typedef struct packed {
    logic [clss_pkg::KIND_W-1:0]   kind;
    logic [clss_pkg::ID_W-1:0]     service_id;
    logic [clss_pkg::HANDLE_W-1:0] socket_handle;
    logic [clss_pkg::LIMIT_W-1:0]  conn_limit;
  } request_t;

  typedef struct packed {
    logic [clss_pkg::STATUS_W-1:0] status;
    logic [clss_pkg::ID_W-1:0]     chosen_id;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // service_id[31:0], socket_handle[63:32], conn_limit[79:64]
  logic [2:0]  s_tuser = '0;   // kind[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[2:0], chosen_id[34:3], zero fill[39:35]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Behavioral copy of the service table and the mode register.
  logic [clss_pkg::MODE_W-1:0]   pick_mode;
  int                            svc_count;
  logic [clss_pkg::ID_W-1:0]     svc_id     [MAX_SERVICES];
  logic [clss_pkg::HANDLE_W-1:0] svc_handle [MAX_SERVICES];
  logic [clss_pkg::LIMIT_W-1:0]  svc_cap    [MAX_SERVICES];
  logic [clss_pkg::LIMIT_W-1:0]  svc_conns  [MAX_SERVICES];

  request_t request_backlog[$];
  answer_t  pending_answers[$];
  request_t in_service;

  logic [clss_pkg::ID_W-1:0]     id_pool     [POOL_SIZE];
  logic [clss_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

  int errors = 0;
  int quiet_cycles = 0;
  int tx_pause = 0;
  int rx_pause = 0;
  int hold_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit sprint = 1'b0;
  bit stall_request = 1'b0;
  bit stall_served = 1'b0;

  capacity_limited_service_selector #(
    .MAX_SERVICES(MAX_SERVICES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // An entry can take a connection when it has no limit or is below it.
  function automatic bit has_room(int i);
    return svc_cap[i] == '0 || svc_conns[i] < svc_cap[i];
  endfunction

  function automatic int find_service(logic [clss_pkg::ID_W-1:0] sid);
    for (int i = 0; i < svc_count; i++) begin
      if (svc_id[i] == sid) return i;
    end
    return -1;
  endfunction

  // Works out the answer to one accepted request and updates the table copy.
  task automatic route_request(input request_t rq);
    answer_t ans;
    int      k;
    int      best;
    ans.status    = clss_pkg::ST_OK;
    ans.chosen_id = '0;
    case (rq.kind)
      clss_pkg::KIND_SELECT: begin
        if (pick_mode == clss_pkg::MODE_ECHO) begin
          ans.chosen_id = '0;
        end else if (svc_count == 0) begin
          ans.status = clss_pkg::ST_NO_SERVICE;
        end else if (pick_mode == clss_pkg::MODE_SINGLE) begin
          if (has_room(0)) ans.chosen_id = svc_id[0];
          else ans.status = clss_pkg::ST_REFUSED;
        end else begin
          best = -1;
          for (int i = 0; i < svc_count; i++) begin
            if (has_room(i)) begin
              if (pick_mode == clss_pkg::MODE_STOCK) begin
                if (best < 0) best = i;
              end else if (best < 0 || svc_conns[i] < svc_conns[best]) begin
                best = i;
              end
            end
          end
          if (best < 0) ans.status = clss_pkg::ST_REFUSED;
          else ans.chosen_id = svc_id[best];
        end
      end
      clss_pkg::KIND_ATTACH, clss_pkg::KIND_DETACH: begin
        k = find_service(rq.service_id);
        if (k < 0) begin
          ans.status = clss_pkg::ST_NOT_FOUND;
        end else begin
          if (rq.kind == clss_pkg::KIND_ATTACH) begin
            if (svc_conns[k] != clss_pkg::LOAD_MAX) svc_conns[k] = svc_conns[k] + 1'b1;
          end else if (svc_conns[k] != '0) begin
            svc_conns[k] = svc_conns[k] - 1'b1;
          end
          ans.chosen_id = rq.service_id;
        end
      end
      clss_pkg::KIND_ADD: begin
        if (rq.service_id == '0 || rq.socket_handle == clss_pkg::INVALID_HANDLE) begin
          ans.status = clss_pkg::ST_REFUSED;
        end else if (find_service(rq.service_id) >= 0) begin
          ans.chosen_id = rq.service_id;
        end else if (svc_count >= MAX_SERVICES) begin
          ans.status = clss_pkg::ST_FULL;
        end else begin
          svc_id[svc_count]     = rq.service_id;
          svc_handle[svc_count] = rq.socket_handle;
          svc_cap[svc_count]    = rq.conn_limit;
          svc_conns[svc_count]  = '0;
          svc_count++;
          ans.chosen_id = rq.service_id;
        end
      end
      clss_pkg::KIND_REMOVE: begin
        ans.status = clss_pkg::ST_NOT_FOUND;
        k = -1;
        if (rq.socket_handle != clss_pkg::INVALID_HANDLE) begin
          for (int i = 0; i < svc_count; i++) begin
            if (k < 0 && svc_handle[i] == rq.socket_handle) k = i;
          end
        end
        if (k >= 0) begin
          ans.chosen_id = svc_id[k];
          for (int i = k; i + 1 < svc_count; i++) begin
            svc_id[i]     = svc_id[i+1];
            svc_handle[i] = svc_handle[i+1];
            svc_cap[i]    = svc_cap[i+1];
            svc_conns[i]  = svc_conns[i+1];
          end
          svc_count--;
          ans.status = clss_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    pending_answers = {pending_answers, ans};
  endtask

  function automatic void post_request(logic [clss_pkg::KIND_W-1:0]   kind,
                                       logic [clss_pkg::ID_W-1:0]     sid,
                                       logic [clss_pkg::HANDLE_W-1:0] hnd,
                                       logic [clss_pkg::LIMIT_W-1:0]  lim);
    request_t rq;
    rq.kind          = kind;
    rq.service_id    = sid;
    rq.socket_handle = hnd;
    rq.conn_limit    = lim;
    request_backlog = {request_backlog, rq};
  endfunction

  // Mostly well-formed traffic on a small set of ids and handles, with some noise.
  function automatic request_t random_request();
    request_t rq;
    int       r;
    r = $urandom_range(0, 99);
    rq.service_id    = id_pool[$urandom_range(0, POOL_SIZE-1)];
    rq.socket_handle = handle_pool[$urandom_range(0, POOL_SIZE-1)];
    rq.conn_limit    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (r < 25) rq.kind = clss_pkg::KIND_SELECT;
    else if (r < 50) rq.kind = clss_pkg::KIND_ATTACH;
    else if (r < 62) rq.kind = clss_pkg::KIND_DETACH;
    else if (r < 82) rq.kind = clss_pkg::KIND_ADD;
    else if (r < 96) rq.kind = clss_pkg::KIND_REMOVE;
    else rq.kind = kind_t'($urandom_range(5, 7));
    if ($urandom_range(0, 19) == 0) rq.service_id = $urandom;
    if ($urandom_range(0, 39) == 0) rq.service_id = '0;
    if ($urandom_range(0, 19) == 0) begin
      rq.socket_handle = $urandom_range(0, 1) ? clss_pkg::INVALID_HANDLE : $urandom;
    end
    return rq;
  endfunction

  // Register write through the configuration port; only called while idle.
  task automatic write_mode(input logic [clss_pkg::MODE_W-1:0] m);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {clss_pkg::REG_GATE_MODE, 2'b00};
    pwdata  <= {30'($urandom), m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    pick_mode = m;
    // The address still points at the mode register, so it reads back.
    @(negedge clk);
    if (prdata[1:0] !== m) begin
      errors++;
      $display("%0t: gate_mode readback expected %0d, got %0d", $time, m, prdata[1:0]);
    end
  endtask

  // Waits until every posted request has been answered; sampled between edges.
  task automatic drain();
    do @(negedge clk);
    while (request_backlog.size() != 0 || s_tvalid || pending_answers.size() != 0);
  endtask

  // Request driver: presents the backlog with a random pause before each request.
  always @(posedge clk) begin
    logic launch;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_pause = 0;
    end else begin
      launch = s_tvalid;
      if (s_tvalid && s_tready) begin
        route_request(in_service);
        launch = 1'b0;
        if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
        tx_pause = (sprint || tx_calm) ? 0 : $urandom_range(0, 12);
      end
      if (!launch) begin
        if (tx_pause > 0) begin
          tx_pause--;
        end else if (request_backlog.size() != 0) begin
          in_service = request_backlog.pop_front();
          s_tdata <= {in_service.conn_limit, in_service.socket_handle, in_service.service_id};
          s_tuser <= in_service.kind;
          launch = 1'b1;
        end
      end
      s_tvalid <= launch;
    end
  end

  // Result monitor: checks each result and applies random back-pressure.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_pause = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
        end else begin
          want = pending_answers.pop_front();
          if (m_tdata[2:0] !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, m_tdata[2:0]);
          end
          if (m_tdata[34:3] !== want.chosen_id) begin
            errors++;
            $display("%0t: chosen_id expected %h, got %h", $time, want.chosen_id,
                     m_tdata[34:3]);
          end
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_pause = (sprint || rx_calm) ? 0 : $urandom_range(0, 12);
      end else if (!m_tready && rx_pause > 0) begin
        rx_pause--;
      end
      // One long hold-off so that the block backs up into its input.
      if (stall_request && !stall_served) begin
        hold_left = LONG_STALL;
        stall_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (rx_pause == 0);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [clss_pkg::MODE_W-1:0] phase_modes [6];
    request_t                    rq;
    int                          counted;
    int                          n;
    phase_modes = '{clss_pkg::MODE_STOCK, clss_pkg::MODE_BALANCE, clss_pkg::MODE_ECHO,
                    clss_pkg::MODE_SINGLE, clss_pkg::MODE_BALANCE, clss_pkg::MODE_STOCK};
    pick_mode = clss_pkg::MODE_RESET;
    svc_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part in the reset mode: empty table, bad adds, limits, full table.
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_ATTACH, 32'h0000_1234, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_REMOVE, 32'h0, clss_pkg::INVALID_HANDLE, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'h0, 32'h0000_0010, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'h0000_0077, clss_pkg::INVALID_HANDLE, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'h0, 16'h1);
    post_request(clss_pkg::KIND_ATTACH, 32'hFFFF_FFFF, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_DETACH, 32'hFFFF_FFFF, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_DETACH, 32'hFFFF_FFFF, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0055, 16'h3);
    post_request(clss_pkg::KIND_ADD, 32'd1, 32'h0000_1001, 16'hFFFF);
    post_request(clss_pkg::KIND_ADD, 32'd2, 32'h0000_1002, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'd3, 32'h0000_1003, 16'h2);
    post_request(clss_pkg::KIND_ADD, 32'd4, 32'h0000_1004, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'd5, 32'h0000_1005, 16'h1);
    post_request(clss_pkg::KIND_ADD, 32'd6, 32'h0000_1006, 16'h8000);
    post_request(clss_pkg::KIND_ADD, 32'd7, 32'h0000_1007, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'h0000_0099, 32'h0000_1099, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'd3, 32'h0000_2003, 16'h0);
    post_request(kind_t'(5), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    post_request(kind_t'(6), 32'd1, 32'h0000_1001, 16'h0);
    post_request(kind_t'(7), 32'd2, 32'h0, 16'h1);
    post_request(clss_pkg::KIND_REMOVE, 32'h0, 32'h0000_1003, 16'h0);
    post_request(clss_pkg::KIND_REMOVE, 32'h0, 32'h0, 16'h0);
    drain();

    // The other modes on the remaining table.
    write_mode(clss_pkg::MODE_ECHO);
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    drain();
    write_mode(clss_pkg::MODE_STOCK);
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_ATTACH, 32'd1, 32'h0, 16'h0);
    drain();
    write_mode(clss_pkg::MODE_BALANCE);
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    drain();

    // Clear the table, add two services, then load one with a back-to-back attach run.
    n = svc_count;
    for (int i = 0; i < n; i++) begin
      post_request(clss_pkg::KIND_REMOVE, 32'h0, svc_handle[i], 16'h0);
    end
    post_request(clss_pkg::KIND_ADD, 32'hA5A5_0001, 32'h0000_0100, 16'h0);
    post_request(clss_pkg::KIND_ADD, 32'h5A5A_0002, 32'h0000_0200, 16'h0);
    post_request(clss_pkg::KIND_ATTACH, 32'h5A5A_0002, 32'h0, 16'h0);
    for (int i = 0; i < ATTACH_RUN; i++) begin
      post_request(clss_pkg::KIND_ATTACH, 32'hA5A5_0001, 32'h0, 16'h0);
    end
    sprint = 1'b1;
    drain();
    sprint = 1'b0;
    // The lightly loaded service wins both selects, also after a detach on the other.
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_DETACH, 32'hA5A5_0001, 32'h0, 16'h0);
    post_request(clss_pkg::KIND_SELECT, 32'h0, 32'h0, 16'h0);
    drain();

    // Random traffic, one phase per mode setting.
    for (int p = 0; p < 6; p++) begin
      write_mode(phase_modes[p]);
      for (int j = 0; j < POOL_SIZE; j++) begin
        id_pool[j]     = $urandom;
        handle_pool[j] = ($urandom_range(0, 15) == 0) ? 32'h0 : 32'($urandom);
      end
      if (p == 1) stall_request = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        rq = random_request();
        request_backlog = {request_backlog, rq};
        counted++;
      end
      drain();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/clss_pkg.sv
rtl/core/clss_ctrl.sv
rtl/core/clss_dpath.sv
rtl/core/capacity_limited_service_selector.sv
rtl/core/clss_checker.sv
tb/sv/capacity_limited_service_selector_tb.sv
